FILE: rtl/mlbc_pkg.sv
// Shared widths, defaults and command codes for the multi-LED blink controller.
package mlbc_pkg;

  // Field widths of the command and result transfers.
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 2;
  localparam int SPEED_W  = 2;
  localparam int COUNT_W  = 8;
  localparam int OUT_W    = 3;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int TICKS_W    = 8;

  // Default LED count.
  localparam int NUM_LEDS_DEF = 3;

  // Register reset values.
  localparam logic [TICKS_W-1:0] ON_SLOW_RST  = 8'd5;
  localparam logic [TICKS_W-1:0] OFF_SLOW_RST = 8'd5;
  localparam logic [TICKS_W-1:0] ON_MED_RST   = 8'd3;
  localparam logic [TICKS_W-1:0] OFF_MED_RST  = 8'd3;
  localparam logic [TICKS_W-1:0] FAST_RST     = 8'd1;
  localparam logic               ACT_LOW_RST  = 1'b1;
  localparam logic               EXCL_RST     = 1'b0;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ON     = 3'd1,
    CMD_OFF    = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_BLINK  = 3'd4,
    CMD_STOP   = 3'd5
  } cmd_t;

  // Blink speed codes.
  typedef enum logic [SPEED_W-1:0] {
    SPEED_SLOW = 2'd0,
    SPEED_MED  = 2'd1,
    SPEED_FAST = 2'd2
  } speed_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_SLOW  = 3'd0,
    CFG_OFF_SLOW = 3'd1,
    CFG_ON_MED   = 3'd2,
    CFG_OFF_MED  = 3'd3,
    CFG_FAST     = 3'd4,
    CFG_ACT_LOW  = 3'd5,
    CFG_EXCL     = 3'd6
  } cfg_idx_t;

  // One result item.
  typedef struct packed {
    logic [OUT_W-1:0] lit_mask;
    logic [OUT_W-1:0] pin_levels;
    logic [OUT_W-1:0] blinking_mask;
  } res_t;

endpackage

FILE: rtl/mlbc_if.sv
// Valid/ready channel interfaces for commands and results.
interface mlbc_cmd_if;
  import mlbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [IDX_W-1:0]   led_index;
  logic [SPEED_W-1:0] blink_speed;
  logic [COUNT_W-1:0] blink_count;

  modport source (output valid, cmd, led_index, blink_speed, blink_count, input ready);
  modport sink   (input valid, cmd, led_index, blink_speed, blink_count, output ready);
endinterface

interface mlbc_res_if;
  import mlbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] lit_mask;
  logic [OUT_W-1:0] pin_levels;
  logic [OUT_W-1:0] blinking_mask;

  modport source (output valid, lit_mask, pin_levels, blinking_mask, input ready);
  modport sink   (input valid, lit_mask, pin_levels, blinking_mask, output ready);
endinterface

FILE: rtl/multi_led_blink_controller.sv
// Top level of the multi-LED blink controller: command decode, per-LED timers and result buffer.
// The block takes one command per clock cycle while the result buffer has room. All per-LED timer
// and lit-state updates for a command happen in the cycle of its transfer, and the result (lit mask,
// pin levels and blinking mask as they stand after the command) is presented on the result channel
// once it reaches the head entry. A two-entry result buffer sits between the command logic and the
// result channel, so one further command is taken while a result waits; commands are held off only
// when both entries are full. A tick advances every blinking LED by one tick; LEDs are processed in
// index order, which matters in exclusive mode, where an LED that lights darkens all others.
// Configuration registers take effect on the next command and must be written while idle.
module multi_led_blink_controller #(
  parameter int NUM_LEDS = mlbc_pkg::NUM_LEDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [mlbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  mlbc_cmd_if.sink                         in_if,
  mlbc_res_if.source                       out_if
);
  import mlbc_pkg::*;

  localparam int EXT_W = (NUM_LEDS > OUT_W) ? NUM_LEDS : OUT_W;

  // Configuration registers.
  logic [TICKS_W-1:0] on_slow_r, off_slow_r, on_med_r, off_med_r, fast_r;
  logic               act_low_r, excl_r;

  // Per-LED blink state.
  logic [NUM_LEDS-1:0] lit_r, lit_nxt;
  logic [NUM_LEDS-1:0] endless_r, endless_nxt;
  logic [NUM_LEDS-1:0] phase_r, phase_nxt;
  logic [TICKS_W-1:0]  on_cnt_r   [NUM_LEDS];
  logic [TICKS_W-1:0]  on_cnt_nxt [NUM_LEDS];
  logic [TICKS_W-1:0]  off_cnt_r  [NUM_LEDS];
  logic [TICKS_W-1:0]  off_cnt_nxt[NUM_LEDS];
  logic [COUNT_W-1:0]  flash_r    [NUM_LEDS];
  logic [COUNT_W-1:0]  flash_nxt  [NUM_LEDS];
  logic [TICKS_W-1:0]  on_rel_r   [NUM_LEDS];
  logic [TICKS_W-1:0]  on_rel_nxt [NUM_LEDS];
  logic [TICKS_W-1:0]  off_rel_r  [NUM_LEDS];
  logic [TICKS_W-1:0]  off_rel_nxt[NUM_LEDS];

  // Result buffer: head entry drives the port, skid entry catches one more transfer.
  res_t out_r, skid_r, res_nxt;
  logic out_valid_r, skid_valid_r;

  logic                accept, pop, head_free, idx_ok;
  logic [NUM_LEDS-1:0] sel, stop_vec, blink_now, pin_vec;
  logic [EXT_W-1:0]    lit_ext, pin_ext, blink_ext;

  assign in_if.ready = !skid_valid_r;
  assign accept      = in_if.valid && in_if.ready;
  assign pop         = out_valid_r && out_if.ready;
  assign head_free   = !out_valid_r || pop;
  assign idx_ok      = int'(in_if.led_index) < NUM_LEDS;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_slow_r  <= ON_SLOW_RST;
      off_slow_r <= OFF_SLOW_RST;
      on_med_r   <= ON_MED_RST;
      off_med_r  <= OFF_MED_RST;
      fast_r     <= FAST_RST;
      act_low_r  <= ACT_LOW_RST;
      excl_r     <= EXCL_RST;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ON_SLOW:  on_slow_r  <= cfg_wdata[TICKS_W-1:0];
        CFG_OFF_SLOW: off_slow_r <= cfg_wdata[TICKS_W-1:0];
        CFG_ON_MED:   on_med_r   <= cfg_wdata[TICKS_W-1:0];
        CFG_OFF_MED:  off_med_r  <= cfg_wdata[TICKS_W-1:0];
        CFG_FAST:     fast_r     <= cfg_wdata[TICKS_W-1:0];
        CFG_ACT_LOW:  act_low_r  <= cfg_wdata[0];
        CFG_EXCL:     excl_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Decode of the addressed LED.
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      sel[i] = idx_ok && (i == int'(in_if.led_index));
    end
  end

  // Next state for one command. LEDs are visited in index order so that exclusive
  // lighting during a tick darkens earlier LEDs as well.
  always_comb begin
    lit_nxt     = lit_r;
    endless_nxt = endless_r;
    phase_nxt   = phase_r;
    on_cnt_nxt  = on_cnt_r;
    off_cnt_nxt = off_cnt_r;
    flash_nxt   = flash_r;
    on_rel_nxt  = on_rel_r;
    off_rel_nxt = off_rel_r;
    stop_vec    = '0;

    unique case (in_if.cmd)
      CMD_TICK: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (on_rel_r[i] != '0 || off_rel_r[i] != '0) begin
            if (!phase_r[i] && off_cnt_r[i] == '0) begin
              if (endless_r[i] || flash_r[i] != '0) begin
                // Start of a flash.
                phase_nxt[i] = 1'b1;
                if (excl_r) begin
                  lit_nxt = '0;
                end
                lit_nxt[i]     = 1'b1;
                on_cnt_nxt[i]  = on_rel_r[i] - 8'd1;
                off_cnt_nxt[i] = off_rel_r[i];
                if (!endless_r[i]) begin
                  flash_nxt[i] = flash_r[i] - 8'd1;
                end
              end else begin
                stop_vec[i] = 1'b1;
              end
            end else if (phase_r[i]) begin
              if (on_cnt_r[i] != '0) begin
                on_cnt_nxt[i] = on_cnt_r[i] - 8'd1;
              end else begin
                phase_nxt[i]   = 1'b0;
                lit_nxt[i]     = 1'b0;
                off_cnt_nxt[i] = off_cnt_r[i] - 8'd1;
              end
            end else begin
              off_cnt_nxt[i] = off_cnt_r[i] - 8'd1;
            end
          end
        end
      end
      CMD_ON: begin
        if (idx_ok) begin
          lit_nxt = (excl_r ? '0 : lit_r) | sel;
        end
      end
      CMD_OFF: begin
        lit_nxt = lit_r & ~sel;
      end
      CMD_TOGGLE: begin
        if ((lit_r & sel) != '0) begin
          lit_nxt = lit_r & ~sel;
        end else if (idx_ok) begin
          lit_nxt = (excl_r ? '0 : lit_r) | sel;
        end
      end
      CMD_BLINK: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (sel[i]) begin
            // A running sequence on the addressed LED is stopped before the restart.
            lit_nxt[i]     = 1'b0;
            endless_nxt[i] = (in_if.blink_count == '0);
            flash_nxt[i]   = in_if.blink_count;
            phase_nxt[i]   = 1'b0;
            on_cnt_nxt[i]  = '0;
            off_cnt_nxt[i] = '0;
            if (on_rel_r[i] != '0 && off_rel_r[i] != '0) begin
              on_rel_nxt[i]  = '0;
              off_rel_nxt[i] = '0;
            end
            unique case (in_if.blink_speed)
              SPEED_SLOW: begin
                on_rel_nxt[i]  = on_slow_r;
                off_rel_nxt[i] = off_slow_r;
              end
              SPEED_MED: begin
                on_rel_nxt[i]  = on_med_r;
                off_rel_nxt[i] = off_med_r;
              end
              SPEED_FAST: begin
                on_rel_nxt[i]  = fast_r;
                off_rel_nxt[i] = fast_r;
              end
              default: ;
            endcase
          end else if (idx_ok && excl_r && on_rel_r[i] != '0 && off_rel_r[i] != '0) begin
            stop_vec[i] = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        stop_vec = sel;
      end
      default: ;
    endcase

    // Stopping a sequence clears its lane and darkens the LED.
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (stop_vec[i]) begin
        lit_nxt[i]     = 1'b0;
        endless_nxt[i] = 1'b0;
        phase_nxt[i]   = 1'b0;
        on_cnt_nxt[i]  = '0;
        off_cnt_nxt[i] = '0;
        flash_nxt[i]   = '0;
        on_rel_nxt[i]  = '0;
        off_rel_nxt[i] = '0;
      end
    end
  end

  // Result of the command, taken from the updated state.
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      blink_now[i] = (on_rel_r[i] != '0) || (off_rel_r[i] != '0);
    end
    pin_vec   = act_low_r ? ~lit_nxt : lit_nxt;
    lit_ext   = EXT_W'(lit_nxt);
    pin_ext   = EXT_W'(pin_vec);
    blink_ext = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      blink_ext[i] = (on_rel_nxt[i] != '0) || (off_rel_nxt[i] != '0);
    end
    res_nxt.lit_mask      = lit_ext[OUT_W-1:0];
    res_nxt.pin_levels    = pin_ext[OUT_W-1:0];
    res_nxt.blinking_mask = blink_ext[OUT_W-1:0];
  end

  // Blink state registers, updated on each command transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r     <= '0;
      endless_r <= '0;
      phase_r   <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        on_cnt_r[i]  <= '0;
        off_cnt_r[i] <= '0;
        flash_r[i]   <= '0;
        on_rel_r[i]  <= '0;
        off_rel_r[i] <= '0;
      end
    end else if (accept) begin
      lit_r     <= lit_nxt;
      endless_r <= endless_nxt;
      phase_r   <= phase_nxt;
      on_cnt_r  <= on_cnt_nxt;
      off_cnt_r <= off_cnt_nxt;
      flash_r   <= flash_nxt;
      on_rel_r  <= on_rel_nxt;
      off_rel_r <= off_rel_nxt;
    end
  end

  // Two-entry result buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (head_free) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.lit_mask      = out_r.lit_mask;
  assign out_if.pin_levels    = out_r.pin_levels;
  assign out_if.blinking_mask = out_r.blinking_mask;

  // The skid entry is only ever filled behind a full head entry.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while head entry empty");

  // Every command transfer leaves a result waiting.
  a_result_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("command transfer produced no result");

  // An LED is only in its on phase while a blink sequence is active.
  a_phase_needs_blink: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r & ~blink_now) == '0)
    else $error("on phase on an LED that is not blinking");

  // A full skid entry is neither lost nor overwritten until the head entry is popped.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |=> skid_valid_r && $stable(skid_r))
    else $error("skid entry lost or overwritten");

endmodule
